FILE: rtl/ppe_pkg.sv
`default_nettype none

package ppe_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 16;
  localparam int unsigned VALUE_BITS_DEF   = 8;

  localparam int unsigned LEN_CFG_W   = 5;
  localparam logic [LEN_CFG_W-1:0] LEN_RESET = 5'd16;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_SKIP    = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] load_value;
    logic [3:0] position;
  } in_item_t;

  typedef struct packed {
    logic [7:0] element_value;
    logic [3:0] element_index;
    logic       last;
    logic       exhausted;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIVOT,
    ST_SUCC,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_EXHAUST
  } state_e;

  typedef enum logic [1:0] {
    ASEL_PIVOT,
    ASEL_SUCC,
    ASEL_EMIT
  } addr_sel_e;

  typedef struct packed {
    logic      load_we;
    logic      start;
    logic      piv_run;
    logic      succ_run;
    addr_sel_e addr_sel;
    logic      emit_wr;
    logic      out_load_elem;
    logic      out_load_exh;
    logic      flip;
  } dp_cmd_t;

  typedef struct packed {
    logic len_lt2;
    logic piv_hit;
    logic piv_none;
    logic succ_hit;
    logic i_active;
    logic i_final;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/ppe_ram.sv
`default_nettype none

module ppe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

FILE: rtl/ppe_ctrl.sv
`default_nettype none

module ppe_ctrl
  import ppe_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] opcode_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   is_step;

  assign is_step = (opcode_i == OP_ADVANCE) || (opcode_i == OP_SKIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && is_step) begin
          state_d = status_i.len_lt2 ? ST_EXHAUST : ST_PIVOT;
        end
      end
      ST_PIVOT: begin
        if (status_i.piv_hit) begin
          state_d = ST_SUCC;
        end else if (status_i.piv_none) begin
          state_d = ST_EXHAUST;
        end
      end
      ST_SUCC: begin
        if (status_i.succ_hit) begin
          state_d = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (!status_i.i_active || status_i.out_free) begin
          state_d = status_i.i_final ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_EXHAUST: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.addr_sel = ASEL_EMIT;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_we = in_valid_i && (opcode_i == OP_LOAD);
        cmd_o.start   = in_valid_i && is_step;
      end
      ST_PIVOT: begin
        cmd_o.piv_run  = 1'b1;
        cmd_o.addr_sel = ASEL_PIVOT;
      end
      ST_SUCC: begin
        cmd_o.succ_run = 1'b1;
        cmd_o.addr_sel = ASEL_SUCC;
      end
      ST_EMIT_RD: begin
        cmd_o.addr_sel = ASEL_EMIT;
      end
      ST_EMIT_WR: begin
        cmd_o.addr_sel      = ASEL_EMIT;
        cmd_o.emit_wr       = !status_i.i_active || status_i.out_free;
        cmd_o.out_load_elem = cmd_o.emit_wr && status_i.i_active;
        cmd_o.flip          = cmd_o.emit_wr && status_i.i_final;
      end
      ST_EXHAUST: begin
        cmd_o.out_load_exh = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/ppe_datapath.sv
`default_nettype none

module ppe_datapath
  import ppe_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int unsigned VALUE_BITS   = VALUE_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [LEN_CFG_W-1:0] cfg_wdata_i,
  input  wire in_item_t             in_item_i,
  input  wire dp_cmd_t              cmd_i,
  output dp_status_t                status_o,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output out_item_t                 out_item_o
);

  localparam int unsigned IDX_W = $clog2(MAX_ELEMENTS);
  localparam int unsigned LEN_W = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned SW    = ((LEN_W > 4) ? LEN_W : 4) + 1;

  logic [LEN_CFG_W-1:0]  len_cfg_q;
  logic [LEN_W-1:0]      len_eff;

  logic                  skip_q;
  logic [3:0]            pos_q;
  logic                  cur_q;

  logic [IDX_W-1:0]      p_q, p_d;
  logic [IDX_W-1:0]      s_q, s_d;
  logic [IDX_W-1:0]      i_q, i_d;
  logic [IDX_W-1:0]      cmp_idx_q, cmp_idx_d;
  logic                  cmp_valid_q, cmp_valid_d;
  logic                  live_q, live_d;
  logic [IDX_W-1:0]      p_found_q, p_found_d;
  logic [IDX_W-1:0]      s_found_q, s_found_d;
  logic [VALUE_BITS-1:0] piv_val_q, piv_val_d;

  logic [IDX_W-1:0]      raddr_a, raddr_b;
  logic [VALUE_BITS-1:0] rdata_a [2];
  logic [VALUE_BITS-1:0] rdata_b [2];
  logic [VALUE_BITS-1:0] rd_a, rd_b;

  logic                  load_ok;
  logic [IDX_W-1:0]      waddr;
  logic [VALUE_BITS-1:0] wdata;

  logic                  piv_hit, succ_hit;

  out_item_t             out_q;
  logic                  out_valid_q;
  logic                  out_free;

  // Source index after the optional suffix reversal of a skip.
  function automatic logic [IDX_W-1:0] map_src(
    input logic [IDX_W-1:0] k,
    input logic             skip,
    input logic [3:0]       pos,
    input logic [LEN_W-1:0] len
  );
    logic [SW-1:0] kk;
    logic [SW-1:0] sum;
    kk  = SW'(k);
    sum = SW'(pos) + SW'(len) - kk;
    if (skip && (kk > SW'(pos)) && (kk < SW'(len))) begin
      return IDX_W'(sum);
    end
    return k;
  endfunction

  // Index of the stepped arrangement that lands at position i.
  function automatic logic [IDX_W-1:0] step_src(
    input logic [IDX_W-1:0] i,
    input logic [IDX_W-1:0] p,
    input logic [IDX_W-1:0] s,
    input logic [LEN_W-1:0] len
  );
    logic [SW-1:0] ii;
    logic [SW-1:0] pp;
    logic [SW-1:0] jj;
    ii = SW'(i);
    pp = SW'(p);
    jj = pp + SW'(len) - ii;
    if (ii < pp) begin
      return i;
    end else if (ii == pp) begin
      return s;
    end else if (ii < SW'(len)) begin
      return (jj == SW'(s)) ? p : IDX_W'(jj);
    end
    return i;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= LEN_RESET;
    end else if (cfg_we_i) begin
      len_cfg_q <= cfg_wdata_i;
    end
  end

  assign len_eff = (32'(len_cfg_q) > 32'(MAX_ELEMENTS)) ? LEN_W'(MAX_ELEMENTS)
                                                        : LEN_W'(len_cfg_q);

  // Address select for the read ports.
  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    unique case (cmd_i.addr_sel)
      ASEL_PIVOT: begin
        raddr_a = map_src(p_q, skip_q, pos_q, len_eff);
        raddr_b = map_src(p_q + IDX_W'(1), skip_q, pos_q, len_eff);
      end
      ASEL_SUCC: begin
        raddr_a = map_src(s_q, skip_q, pos_q, len_eff);
      end
      ASEL_EMIT: begin
        raddr_a = map_src(step_src(i_q, p_found_q, s_found_q, len_eff),
                          skip_q, pos_q, len_eff);
      end
      default: begin
        raddr_a = '0;
      end
    endcase
  end

  assign rd_a = rdata_a[cur_q];
  assign rd_b = rdata_b[cur_q];

  assign load_ok = cmd_i.load_we && (32'(in_item_i.position) < 32'(MAX_ELEMENTS));
  assign waddr   = cmd_i.load_we ? IDX_W'(in_item_i.position) : i_q;
  assign wdata   = cmd_i.load_we ? VALUE_BITS'(in_item_i.load_value) : rd_a;

  // Two banks: loads go to the current one, a step rewrites the other.
  for (genvar b = 0; b < 2; b++) begin : g_bank
    logic bank_we;
    assign bank_we = (load_ok && (cur_q == 1'(b))) ||
                     (cmd_i.emit_wr && (cur_q != 1'(b)));
    ppe_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_ELEMENTS)
    ) u_bank (
      .clk_i     (clk_i),
      .we_i      (bank_we),
      .waddr_i   (waddr),
      .wdata_i   (wdata),
      .raddr_a_i (raddr_a),
      .raddr_b_i (raddr_b),
      .rdata_a_o (rdata_a[b]),
      .rdata_b_o (rdata_b[b])
    );
  end

  assign piv_hit  = cmd_i.piv_run && cmp_valid_q && (rd_a > rd_b);
  assign succ_hit = cmd_i.succ_run && cmp_valid_q && (rd_a < piv_val_q);

  // Scan pipeline: issue one index per cycle, compare its data in the next cycle.
  always_comb begin
    p_d         = p_q;
    s_d         = s_q;
    i_d         = i_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_valid_d = cmp_valid_q;
    live_d      = live_q;
    p_found_d   = p_found_q;
    s_found_d   = s_found_q;
    piv_val_d   = piv_val_q;
    if (cmd_i.start) begin
      p_d         = IDX_W'(len_eff - LEN_W'(2));
      cmp_valid_d = 1'b0;
      live_d      = 1'b1;
    end else if (cmd_i.piv_run) begin
      if (piv_hit) begin
        p_found_d   = cmp_idx_q;
        piv_val_d   = rd_a;
        s_d         = IDX_W'(len_eff - LEN_W'(1));
        cmp_valid_d = 1'b0;
        live_d      = 1'b1;
      end else begin
        cmp_valid_d = live_q;
        cmp_idx_d   = p_q;
        if (p_q == '0) begin
          live_d = 1'b0;
        end else begin
          p_d = p_q - IDX_W'(1);
        end
      end
    end else if (cmd_i.succ_run) begin
      if (succ_hit) begin
        s_found_d   = cmp_idx_q;
        i_d         = '0;
        cmp_valid_d = 1'b0;
      end else begin
        cmp_valid_d = live_q;
        cmp_idx_d   = s_q;
        if (s_q == '0) begin
          live_d = 1'b0;
        end else begin
          s_d = s_q - IDX_W'(1);
        end
      end
    end else if (cmd_i.emit_wr && !status_o.i_final) begin
      i_d = i_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_valid_q <= 1'b0;
      live_q      <= 1'b0;
      cur_q       <= 1'b0;
    end else begin
      cmp_valid_q <= cmp_valid_d;
      live_q      <= live_d;
      if (cmd_i.flip) begin
        cur_q <= ~cur_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q       <= p_d;
    s_q       <= s_d;
    i_q       <= i_d;
    cmp_idx_q <= cmp_idx_d;
    p_found_q <= p_found_d;
    s_found_q <= s_found_d;
    piv_val_q <= piv_val_d;
    if (cmd_i.start) begin
      skip_q <= (in_item_i.opcode == OP_SKIP);
      pos_q  <= in_item_i.position;
    end
  end

  // Output register: hold until the transfer completes.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load_elem || cmd_i.out_load_exh) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_elem) begin
      out_q.element_value <= 8'(rd_a);
      out_q.element_index <= 4'(i_q);
      out_q.last          <= (LEN_W'(i_q) + LEN_W'(1)) == len_eff;
      out_q.exhausted     <= 1'b0;
    end else if (cmd_i.out_load_exh) begin
      out_q.element_value <= '0;
      out_q.element_index <= '0;
      out_q.last          <= 1'b1;
      out_q.exhausted     <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign status_o.len_lt2  = len_eff < LEN_W'(2);
  assign status_o.piv_hit  = piv_hit;
  assign status_o.piv_none = cmd_i.piv_run && cmp_valid_q && !piv_hit && (cmp_idx_q == '0);
  assign status_o.succ_hit = succ_hit;
  assign status_o.i_active = LEN_W'(i_q) < len_eff;
  assign status_o.i_final  = 32'(i_q) == (MAX_ELEMENTS - 1);
  assign status_o.out_free = out_free;

endmodule

`default_nettype wire

FILE: rtl/prev_permutation_engine_unit.sv
// Previous-permutation engine.
// Input channel (in_valid_i/in_ready_o, in_item_i): load writes one element;
// advance steps the arrangement back one permutation; skip reverses the suffix
// after the given position, then steps. Opcode 3 is dropped.
// Output channel (out_valid_o/out_ready_i, out_item_o): after a step, one transfer
// per active element, index 0 first, last set on the final one. With no
// previous permutation a single transfer with exhausted and last set follows and
// the arrangement is left as it was.
// cfg_we_i/cfg_wdata_i set the active length (reset 16, capped at MAX_ELEMENTS);
// write it only while the block is idle.
// A step runs a pivot scan, a successor scan and a rewrite pass: the pivot and
// successor scans read the arrangement memory one index per cycle, and the
// rewrite pass reads and then writes each entry of the other bank (every entry,
// so the banks stay in step). The next item is taken as soon as the pass ends,
// while the final result may still sit in the output register. A stalled
// receiver holds the rewrite pass.
// Reset returns the length to 16 and empties the output; the element memory
// itself is not cleared and holds no defined value until loaded.
`default_nettype none

module prev_permutation_engine_unit
  import ppe_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int unsigned VALUE_BITS   = VALUE_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_item_t             in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_item_t                 out_item_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [LEN_CFG_W-1:0] cfg_wdata_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ppe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (in_item_i.opcode),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ppe_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
